[design/rbq_pkg.sv]
// Shared types and constants for the resonant biquad controller.
package rbq_pkg;

    localparam int WORD_W = 32;
    localparam int ACC_W  = 67;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [1:0] t_cfg_index;

    localparam t_cfg_index CFG_B0 = 2'd0;
    localparam t_cfg_index CFG_B2 = 2'd1;
    localparam t_cfg_index CFG_A1 = 2'd2;
    localparam t_cfg_index CFG_A2 = 2'd3;

    localparam t_word DRIVE_MAX = 32'sh7fff_ffff;
    localparam t_word DRIVE_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [WORD_W-1:0] b0;
        logic signed [WORD_W-1:0] b2;
        logic signed [WORD_W-1:0] a1;
        logic signed [WORD_W-1:0] a2;
    } t_coefs;

    typedef struct packed {
        logic                     sat;
        logic signed [WORD_W-1:0] y;
    } t_status;

endpackage

[design/rbq_cfg.sv]
// Coefficient register file written through the configuration channel.
module rbq_cfg #(
    parameter int FRAC_BITS = 29
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  rbq_pkg::t_cfg_index i_cfg_index,
    input  rbq_pkg::t_word      i_cfg_data,
    output logic                o_cfg_ready,
    output rbq_pkg::t_coefs     o_coefs
);
    import rbq_pkg::*;

    t_coefs r_coefs;

    assign o_cfg_ready = 1'b1;
    assign o_coefs     = r_coefs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= '0;
            r_coefs.b2 <= '0;
            r_coefs.a1 <= '0;
            r_coefs.a2 <= t_word'(32'd1 << FRAC_BITS);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_B0: r_coefs.b0 <= i_cfg_data;
                CFG_B2: r_coefs.b2 <= i_cfg_data;
                CFG_A1: r_coefs.a1 <= i_cfg_data;
                CFG_A2: r_coefs.a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

[design/rbq_core.sv]
// Biquad recurrence: products, wide sum, floor shift, saturation and history state.
module rbq_core #(
    parameter int FRAC_BITS = 29
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  rbq_pkg::t_word       i_x,
    input  rbq_pkg::t_coefs      i_coefs,
    output rbq_pkg::t_status     o_status,
    output logic [FRAC_BITS-1:0] o_frac
);
    import rbq_pkg::*;

    t_word                  r_in_hist1;
    t_word                  r_in_hist2;
    t_word                  r_out_hist1;
    t_word                  r_out_hist2;
    logic [FRAC_BITS-1:0]   r_frac;

    logic signed [2*WORD_W-1:0] p_b0;
    logic signed [2*WORD_W-1:0] p_b2;
    logic signed [2*WORD_W-1:0] p_a1;
    logic signed [2*WORD_W-1:0] p_a2;
    logic signed [ACC_W-1:0]    acc;
    logic signed [ACC_W-1:0]    scaled;
    logic                       sat_hi;
    logic                       sat_lo;
    t_word                      y;

    always_comb begin
        p_b0   = i_coefs.b0 * i_x;
        p_b2   = i_coefs.b2 * r_in_hist2;
        p_a1   = i_coefs.a1 * r_out_hist1;
        p_a2   = i_coefs.a2 * r_out_hist2;
        acc    = ACC_W'(p_b0) + ACC_W'(p_b2) - ACC_W'(p_a1) - ACC_W'(p_a2)
                 + $signed({{(ACC_W-FRAC_BITS){1'b0}}, r_frac});
        scaled = acc >>> FRAC_BITS;
        sat_hi = !scaled[ACC_W-1] && (|scaled[ACC_W-2:WORD_W-1]);
        sat_lo = scaled[ACC_W-1] && !(&scaled[ACC_W-2:WORD_W-1]);
        if (sat_hi) begin
            y = DRIVE_MAX;
        end else if (sat_lo) begin
            y = DRIVE_MIN;
        end else begin
            y = scaled[WORD_W-1:0];
        end
    end

    assign o_status.sat = sat_hi | sat_lo;
    assign o_status.y   = y;
    assign o_frac       = r_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_hist1  <= '0;
            r_in_hist2  <= '0;
            r_out_hist1 <= '0;
            r_out_hist2 <= '0;
            r_frac      <= '0;
        end else if (i_step) begin
            r_in_hist2  <= r_in_hist1;
            r_in_hist1  <= i_x;
            r_out_hist2 <= r_out_hist1;
            r_out_hist1 <= y;
            r_frac      <= (sat_hi | sat_lo) ? '0 : acc[FRAC_BITS-1:0];
        end
    end

endmodule

[design/resonant_biquad_q29_unit.sv]
// Top level of the resonant biquad controller with input and output word registers.
// An accepted word moves from the input register through the core into the output
// register. Throughput: one word per cycle while not stalled by i_ready; the output
// feedback closes within one pass through the four parallel multipliers, the wide sum
// and the saturation logic. Reset clears the histories, the residual, both valid flags
// and loads the coefficient reset values; words are accepted as soon as reset ends.
module resonant_biquad_q29_unit #(
    parameter int FRAC_BITS = 29
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rbq_pkg::t_word      i_sample_in,
    output logic                o_valid,
    input  logic                i_ready,
    output rbq_pkg::t_word      o_drive_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  rbq_pkg::t_cfg_index i_cfg_index,
    input  rbq_pkg::t_word      i_cfg_data
);
    import rbq_pkg::*;

    logic                 r_in_valid;
    logic                 n_in_valid;
    t_word                r_x;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_word                r_drive;
    logic                 advance;
    logic                 in_fire;
    t_coefs               coefs;
    t_status              status;
    logic [FRAC_BITS-1:0] frac;

    rbq_cfg #(
        .FRAC_BITS(FRAC_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_coefs     (coefs)
    );

    rbq_core #(
        .FRAC_BITS(FRAC_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_x      (r_x),
        .i_coefs  (coefs),
        .o_status (status),
        .o_frac   (frac)
    );

    assign advance     = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_in_valid || advance;
    assign in_fire     = i_valid && o_ready;
    assign o_valid     = r_out_valid;
    assign o_drive_out = r_drive;

    always_comb begin
        n_in_valid  = in_fire | (r_in_valid & !advance);
        n_out_valid = advance | (r_out_valid & !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x <= i_sample_in;
        end
        if (advance) begin
            r_drive <= status.y;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("Output valid after reset.");

    a_sat_clears_residual: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && status.sat |=> frac == '0)
        else $error("Residual kept after saturation.");

    a_empty_output_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_ready)
        else $error("Input stalled while the output register is empty.");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_in_valid)
        else $error("Accepted word lost in the input register.");

endmodule

[tb/tb_resonant_biquad_q29_unit.sv]
// Self-checking testbench for the resonant biquad controller unit.
`timescale 1ns / 100ps

module tb_resonant_biquad_q29_unit;
    import rbq_pkg::*;

    localparam int FRAC_BITS = 29;
    localparam int ACC_BITS = 72;
    localparam int DRAIN_CYCLES = 4;
    localparam int STALL_LIMIT = 1000;
    localparam t_word Q_ONE = t_word'(1) << FRAC_BITS;

    typedef enum {SET_RESONATOR, SET_RANDOM, SET_EXTREME, SET_FINE} t_coef_set;

    class DriveScoreboard;
        t_word b0, b2, a1, a2;
        t_word in_prev1, in_prev2, out_prev1, out_prev2;
        logic [FRAC_BITS-1:0] residual;
        t_word drive_q[$];
        int errors;
        int checked;
        int saturations;

        function new();
            b0 = '0;
            b2 = '0;
            a1 = '0;
            a2 = Q_ONE;
            in_prev1 = '0;
            in_prev2 = '0;
            out_prev1 = '0;
            out_prev2 = '0;
            residual = '0;
            errors = 0;
            checked = 0;
            saturations = 0;
        endfunction

        function logic signed [ACC_BITS-1:0] wide(t_word v);
            return v;
        endfunction

        function void set_coef(t_cfg_index idx, t_word d);
            case (idx)
                CFG_B0: b0 = d;
                CFG_B2: b2 = d;
                CFG_A1: a1 = d;
                CFG_A2: a2 = d;
                default: ;
            endcase
        endfunction

        function void note_sample(t_word x);
            logic signed [ACC_BITS-1:0] acc;
            logic signed [ACC_BITS-1:0] scaled;
            logic signed [ACC_BITS-1:0] frac_ext;
            t_word y;
            bit sat;
            frac_ext = {{(ACC_BITS-FRAC_BITS){1'b0}}, residual};
            acc = wide(b0) * wide(x) + wide(b2) * wide(in_prev2)
                - wide(a1) * wide(out_prev1) - wide(a2) * wide(out_prev2) + frac_ext;
            scaled = acc >>> FRAC_BITS;
            sat = 1'b1;
            if (scaled > wide(DRIVE_MAX)) begin
                y = DRIVE_MAX;
            end else if (scaled < wide(DRIVE_MIN)) begin
                y = DRIVE_MIN;
            end else begin
                y = scaled[WORD_W-1:0];
                sat = 1'b0;
            end
            residual = sat ? '0 : acc[FRAC_BITS-1:0];
            if (sat) saturations++;
            in_prev2 = in_prev1;
            in_prev1 = x;
            out_prev2 = out_prev1;
            out_prev1 = y;
            drive_q.push_back(y);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_drive(t_word got);
            t_word want;
            if (drive_q.size() == 0) begin
                report($sformatf("drive word %0d arrived with none expected", got));
            end else begin
                want = drive_q.pop_front();
                checked++;
                if (got !== want)
                    report($sformatf("drive_out %0d, expected %0d", got, want));
            end
        endtask

        task check_empty();
            if (drive_q.size() != 0)
                report($sformatf("%0d drive words never arrived", drive_q.size()));
        endtask

        function int pending();
            return drive_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_ready;
    t_word i_sample_in;
    logic o_valid;
    logic i_ready;
    t_word o_drive_out;
    logic i_cfg_valid;
    logic o_cfg_ready;
    t_cfg_index i_cfg_index;
    t_word i_cfg_data;

    DriveScoreboard sb = new();
    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    int samples_sent = 0;
    int coef_writes = 0;
    int coef_sets = 0;
    int idle_cycles = 0;

    resonant_biquad_q29_unit #(.FRAC_BITS(FRAC_BITS)) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_sample_in(i_sample_in),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_drive_out(o_drive_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        int stall_left;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stalls_on && stall_left == 0 && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 9);
            if (!stalls_on) stall_left = 0;
            i_ready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_drive(o_drive_out);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Handshake timeout after %0d idle cycles", idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic push_sample(t_word x);
        i_valid <= 1'b1;
        i_sample_in <= x;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        sb.note_sample(x);
        samples_sent++;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic write_coef(t_cfg_index idx, t_word d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_coef(idx, d);
        coef_writes++;
    endtask

    task automatic write_coefs(t_word b0, t_word b2, t_word a1, t_word a2);
        write_coef(CFG_B0, b0);
        write_coef(CFG_B2, b2);
        write_coef(CFG_A1, a1);
        write_coef(CFG_A2, a2);
        i_cfg_valid <= 1'b0;
        coef_sets++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_word pick_extreme();
        case ($urandom_range(0, 6))
            0: return DRIVE_MIN;
            1: return DRIVE_MAX;
            2: return '0;
            3: return Q_ONE;
            4: return -Q_ONE;
            5: return t_word'(1);
            default: return t_word'(-1);
        endcase
    endfunction

    function automatic t_word rand_sample();
        case ($urandom_range(0, 9))
            0: return pick_extreme();
            1, 2: return $urandom;
            default: return $signed($urandom) >>> $urandom_range(8, 30);
        endcase
    endfunction

    function automatic t_word rand_fine();
        return $signed($urandom) >>> $urandom_range(10, 31);
    endfunction

    task automatic random_phase(t_coef_set kind, int count, bit pause_mid);
        t_word c_b0;
        t_word c_a1;
        t_word c_a2;
        case (kind)
            SET_RESONATOR: begin
                c_b0 = $urandom_range(0, 1 << 24);
                if ($urandom_range(0, 1)) c_b0 = -c_b0;
                c_a1 = $urandom_range(1 << 29, (1 << 30) - 1);
                c_a2 = Q_ONE - t_word'($urandom_range(0, 1 << 20));
                write_coefs(c_b0, -c_b0, -c_a1, c_a2);
            end
            SET_RANDOM: write_coefs($urandom, $urandom, $urandom, $urandom);
            SET_EXTREME: write_coefs(pick_extreme(), pick_extreme(), pick_extreme(),
                                     pick_extreme());
            default: write_coefs(rand_fine(), rand_fine(), rand_fine(), rand_fine());
        endcase
        for (int i = 0; i < count; i++) begin
            if (pause_mid && i == count / 2) drain();
            push_sample(rand_sample());
        end
        drain();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_sample_in <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_B0;
        i_cfg_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset coefficients: every output should stay at zero.
        push_sample(DRIVE_MAX);
        push_sample(DRIVE_MIN);
        push_sample(t_word'(1234));
        drain();

        // Unity gain passes the input straight through.
        write_coefs(Q_ONE, '0, '0, '0);
        push_sample('0);
        push_sample(t_word'(1));
        push_sample(t_word'(-1));
        push_sample(DRIVE_MAX);
        push_sample(DRIVE_MIN);
        push_sample(32'sh5555_5555);
        push_sample(32'shaaaa_aaaa);
        drain();

        // Extreme coefficients drive the accumulator into both saturation limits.
        write_coefs(DRIVE_MAX, DRIVE_MIN, DRIVE_MIN, DRIVE_MIN);
        push_sample(DRIVE_MAX);
        push_sample(DRIVE_MIN);
        push_sample(DRIVE_MAX);
        push_sample(t_word'(-1));
        push_sample(DRIVE_MIN);
        drain();

        // Tiny gains leave most of the sum in the carried fraction.
        write_coefs(t_word'(3), t_word'(-1), '0, '0);
        push_sample(32'sh1234_5678);
        push_sample(32'sh1234_5678);
        push_sample(DRIVE_MAX);
        push_sample(32'sh1234_5678);
        push_sample(DRIVE_MIN);
        drain();

        random_phase(SET_RESONATOR, 170, 1'b0);
        random_phase(SET_RANDOM, 170, 1'b1);
        gaps_on = 1'b0;
        random_phase(SET_EXTREME, 170, 1'b0);
        gaps_on = 1'b1;
        stalls_on = 1'b0;
        random_phase(SET_FINE, 170, 1'b0);
        stalls_on = 1'b1;
        random_phase(SET_RESONATOR, 170, 1'b0);
        random_phase(SET_RANDOM, 170, 1'b0);
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        random_phase(SET_RESONATOR, 170, 1'b0);

        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        sb.check_empty();
        $display("Run covered %0d samples over %0d coefficient sets (%0d register writes).",
                 samples_sent, coef_sets, coef_writes);
        $display("Checked %0d drive words, %0d of them clamped at a limit.",
                 sb.checked, sb.saturations);
        if (sb.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
